// File: hw/rtl/egcd_pkg.sv
package egcd_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } gcd_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_status_t;

endpackage

// File: hw/rtl/egcd_rem.sv
module egcd_rem
  import egcd_pkg::*;
#(
  parameter int unsigned WIDTH = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic [WIDTH-1:0] rem_o,
  output rem_status_t      status_o
);

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] LastStep = CntW'(WIDTH - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] dsr_q, dsr_d;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // one restoring step a cycle, quotient bits discarded
  assign trial = {rem_q, dvd_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[WIDTH]) begin
        rem_d = trial[WIDTH-1:0];
      end else begin
        rem_d = diff[WIDTH-1:0];
      end
      dvd_d = {dvd_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign rem_o           = rem_q;
  assign status_o.busy   = busy_q;
  assign status_o.done   = done_q;

endmodule

// File: hw/rtl/euclid_gcd_unit_core.sv
// Channel | Signals                                      | Direction
// input   | in_valid_i, in_ready_o, first/second_value_i | into block
// output  | out_valid_o, out_ready_i, divisor_o          | out of block
//
// Each remainder round is a check in ST_CHECK, a run of the single bit-serial
// divider in ST_DIV and a handover back to ST_CHECK; a swap is done in
// ST_CHECK alone.
// in_ready_o is high only in the idle state. The result sits in an output
// register, so a new transaction may be taken while it waits.
// rst_ni clears the sequencer and output valid asynchronously.
module euclid_gcd_unit_core
  import egcd_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 63
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [OPERAND_WIDTH-1:0] first_value_i,
  input  logic [OPERAND_WIDTH-1:0] second_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [OPERAND_WIDTH-1:0] divisor_o
);

  gcd_state_e state_q, state_d;
  logic [OPERAND_WIDTH-1:0] x_q, x_d;
  logic [OPERAND_WIDTH-1:0] y_q, y_d;
  logic [OPERAND_WIDTH-1:0] res_q, res_d;
  logic                     out_valid_q, out_valid_d;

  logic                     rem_start;
  logic [OPERAND_WIDTH-1:0] rem_val;
  rem_status_t              rem_stat;

  egcd_rem #(
    .WIDTH(OPERAND_WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(x_q),
    .divisor_i (y_q),
    .rem_o     (rem_val),
    .status_o  (rem_stat)
  );

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    rem_start   = 1'b0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          x_d     = first_value_i;
          y_d     = second_value_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (y_q == '0) begin
          state_d = ST_FINISH;
        end else if (x_q < y_q) begin
          x_d = y_q;
          y_d = x_q;
        end else begin
          rem_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done && !rem_stat.busy) begin
          x_d     = y_q;
          y_d     = rem_val;
          state_d = ST_CHECK;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          res_d       = x_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign divisor_o   = res_q;

endmodule

// File: hw/rtl/egcd_chk.sv
module egcd_chk #(
  parameter int unsigned OPERAND_WIDTH = 63
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [OPERAND_WIDTH-1:0] first_value_i,
  input logic [OPERAND_WIDTH-1:0] second_value_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [OPERAND_WIDTH-1:0] divisor_o
);

  logic [OPERAND_WIDTH-1:0] a_q;
  logic [OPERAND_WIDTH-1:0] b_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_q <= first_value_i;
      b_q <= second_value_i;
    end
  end

  // not ready in the cycle after each accepted input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("egcd_chk: ready straight after input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(divisor_o))
    else $error("egcd_chk: stalled result dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && b_q == '0 |-> divisor_o == a_q)
    else $error("egcd_chk: zero second operand must return the first");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && a_q != '0 |-> divisor_o != '0 && divisor_o <= a_q)
    else $error("egcd_chk: divisor out of range for first operand");

endmodule

bind euclid_gcd_unit_core egcd_chk #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_egcd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .first_value_i (first_value_i),
  .second_value_i(second_value_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .divisor_o     (divisor_o)
);
